// File: sv/cdts_pkg.sv
// ----------------------------------------------------------------------------
// cdts_pkg
// Shared widths, constants and types for the column depth terrain shader.
// ----------------------------------------------------------------------------
`default_nettype none

package cdts_pkg;

  // geometry
  localparam int unsigned ColumnsDef = 1024;
  localparam int unsigned CoordW     = 12;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned RunW       = 10;
  localparam logic [RunW-1:0] RunMax = '1;

  // pipeline: stage 1 = store read, stage StgN = output register
  localparam int unsigned StgN = 8;

  // coordinate hash
  localparam logic [31:0] HashMulX   = 32'd374761393;
  localparam logic [31:0] HashMulY   = 32'd668265263;
  localparam logic [31:0] HashMulMix = 32'd1274126177;

  // hash residues: fold the upper half with 2^16 mod m, then divide by
  // reciprocal multiplication (exact over the folded range)
  localparam int unsigned Fold29W  = 21;
  localparam int unsigned Fold37W  = 20;
  localparam int unsigned Recip29W = 28;
  localparam int unsigned Recip37W = 27;
  localparam int unsigned RecipSh  = 32;
  localparam logic [Fold29W-1:0]  Fold29Hi = 21'd25;
  localparam logic [Fold37W-1:0]  Fold37Hi = 20'd9;
  localparam logic [Recip29W-1:0] Recip29  = 28'd148102321;
  localparam logic [Recip37W-1:0] Recip37  = 27'd116080198;
  localparam logic [Fold29W-1:0]  Mod29    = 21'd29;
  localparam logic [Fold37W-1:0]  Mod37    = 20'd37;
  localparam int unsigned NoiseW = 5;

  // darkening
  localparam int unsigned ScaleW = 17;
  localparam logic [ScaleW-1:0] ScaleOne  = 17'd65536;
  localparam logic [ScaleW-1:0] DarkStep  = 17'd72;
  localparam logic [ScaleW-1:0] DarkLimit = 17'd24904;

  // per-stage handshake control shared by the datapath modules
  typedef struct packed {
    logic [StgN:1] ld;     // stage register takes a new request (or bubble)
    logic [StgN:1] valid;  // stage holds a request
  } pipe_ctl_t;

endpackage

`default_nettype wire

// File: sv/column_depth_terrain_shader.sv
// ----------------------------------------------------------------------------
// column_depth_terrain_shader
// Shades raster-order terrain pixels by the solid run above them.
// ----------------------------------------------------------------------------
// Input channel: pixel_x_i / pixel_y_i / is_solid_i under in_valid_i and
// in_ready_o. Output channel: red_o / green_o / blue_o / alpha_o under
// out_valid_o and out_ready_i. Every input request yields exactly one
// output request, in order.
// Throughput: one pixel per clock while out_ready_i does not stall the pipe. The run memory is read
// when a request is taken and written back as it leaves stage 1; a request to the same column
// right behind it takes the written value through a bypass register.
// Pipeline: eight register stages, from the one loaded at the edge that took
// a request to the output register (store read, hash multiply, residue
// reciprocal multiplies, darkening multiply, noise add).
// Stall: each stage holds its request while the next is full, so bubbles
// close up and new pixels keep entering until the pipe is full.
// Reset: the pipe empties; the run memory is not cleared and a column must
// see its top row (pixel_y_i = 0) before lower rows are shaded.
// ----------------------------------------------------------------------------
`default_nettype none

module column_depth_terrain_shader import cdts_pkg::*; #(
  parameter int unsigned Columns = ColumnsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CoordW-1:0] pixel_x_i,
  input  wire logic [CoordW-1:0] pixel_y_i,
  input  wire logic              is_solid_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [ChanW-1:0]       red_o,
  output logic [ChanW-1:0]       green_o,
  output logic [ChanW-1:0]       blue_o,
  output logic [ChanW-1:0]       alpha_o
);

  pipe_ctl_t         ctl;
  logic [StgN:1]     valid_q;
  logic [RunW-1:0]   depth;
  logic              solid;
  logic [NoiseW-1:0] noise_res;
  logic              stone;

  always_comb begin
    ctl.valid     = valid_q;
    ctl.ld[StgN]  = !valid_q[StgN] || out_ready_i;
    for (int k = StgN - 1; k >= 1; k--) begin
      ctl.ld[k] = !valid_q[k] || ctl.ld[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ctl.ld[1]) valid_q[1] <= in_valid_i;
      for (int k = 2; k <= StgN; k++) begin
        if (ctl.ld[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  assign in_ready_o  = ctl.ld[1];
  assign out_valid_o = valid_q[StgN];

  cdts_run_store #(
    .Columns (Columns)
  ) u_run_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .is_solid_i (is_solid_i),
    .depth_o    (depth),
    .solid_o    (solid)
  );

  cdts_hash u_hash (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .noise_res_o (noise_res),
    .stone_o     (stone)
  );

  cdts_shade u_shade (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .depth_i     (depth),
    .solid_i     (solid),
    .noise_res_i (noise_res),
    .stone_i     (stone),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .alpha_o     (alpha_o)
  );

endmodule

`default_nettype wire

// File: sv/cdts_run_store.sv
// ----------------------------------------------------------------------------
// cdts_run_store
// Per-column run-length memory: read on accept, write back one stage later,
// with a bypass for a request directly behind one to the same column.
// ----------------------------------------------------------------------------
`default_nettype none

module cdts_run_store import cdts_pkg::*; #(
  parameter int unsigned Columns = ColumnsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pipe_ctl_t         ctl_i,
  input  wire logic [CoordW-1:0] pixel_x_i,
  input  wire logic [CoordW-1:0] pixel_y_i,
  input  wire logic              is_solid_i,
  output logic [RunW-1:0]        depth_o,
  output logic                   solid_o
);

  localparam int unsigned AddrW = (Columns > 1) ? $clog2(Columns) : 1;

  logic [RunW-1:0] mem [Columns];

  logic [AddrW-1:0] addr_d, addr_q;
  logic             in_range_d, in_range_q;
  logic             y_zero_q, solid_q;
  logic             byp_d, byp_q;
  logic [RunW-1:0]  byp_data_q;
  logic [RunW-1:0]  rdata_q;
  logic [RunW-1:0]  depth_d, depth_q, run_raw, run_next, wr_data;
  logic             solid2_q;
  logic             wr_en;

  assign addr_d     = pixel_x_i[AddrW-1:0];
  assign in_range_d = {1'b0, pixel_x_i} < (CoordW+1)'(Columns);

  always_comb begin
    run_raw  = byp_q ? byp_data_q : rdata_q;
    depth_d  = (in_range_q && !y_zero_q) ? run_raw : '0;
    run_next = (depth_d == RunMax) ? RunMax : depth_d + RunW'(1);
    wr_data  = solid_q ? run_next : '0;
    wr_en    = ctl_i.valid[1] && ctl_i.ld[2] && in_range_q;
    // the write of the request leaving stage 1 is not yet in the read data
    byp_d    = wr_en && (addr_d == addr_q);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[addr_q] <= wr_data;
    end
    if (ctl_i.ld[1]) begin
      rdata_q <= mem[addr_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (ctl_i.ld[1]) begin
      byp_q <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[1]) begin
      addr_q     <= addr_d;
      in_range_q <= in_range_d;
      y_zero_q   <= (pixel_y_i == '0);
      solid_q    <= is_solid_i;
      byp_data_q <= wr_data;
    end
    if (ctl_i.ld[2]) begin
      depth_q  <= depth_d;
      solid2_q <= solid_q;
    end
  end

  assign depth_o = depth_q;
  assign solid_o = solid2_q;

endmodule

`default_nettype wire

// File: sv/cdts_hash.sv
// ----------------------------------------------------------------------------
// cdts_hash
// Coordinate hash and its residues mod 29 (noise) and mod 37 (stone pick).
// ----------------------------------------------------------------------------
`default_nettype none

module cdts_hash import cdts_pkg::*; (
  input  wire logic              clk_i,
  input  wire pipe_ctl_t         ctl_i,
  input  wire logic [CoordW-1:0] pixel_x_i,
  input  wire logic [CoordW-1:0] pixel_y_i,
  output logic [NoiseW-1:0]      noise_res_o,
  output logic                   stone_o
);

  localparam int unsigned P29W = Fold29W + Recip29W;
  localparam int unsigned P37W = Fold37W + Recip37W;
  localparam int unsigned Q29W = P29W - RecipSh;
  localparam int unsigned Q37W = P37W - RecipSh;

  logic [31:0]        hx_q, hy_q, h0, mix_q, h1, hash_q;
  logic [Fold29W-1:0] v29_d, v29_q, v29b_q, r29;
  logic [Fold37W-1:0] v37_d, v37_q, v37b_q, r37;
  logic [P29W-1:0]    p29;
  logic [P37W-1:0]    p37;
  logic [Q29W-1:0]    q29_q;
  logic [Q37W-1:0]    q37_q;
  logic [NoiseW-1:0]  noise_q;
  logic               stone_q;

  always_comb begin
    h0    = hx_q + hy_q;
    h1    = mix_q * HashMulMix;
    v29_d = Fold29W'(hash_q[15:0]) + Fold29W'(hash_q[31:16]) * Fold29Hi;
    v37_d = Fold37W'(hash_q[15:0]) + Fold37W'(hash_q[31:16]) * Fold37Hi;
    p29   = P29W'(v29_q) * P29W'(Recip29);
    p37   = P37W'(v37_q) * P37W'(Recip37);
    r29   = v29b_q - Fold29W'(q29_q) * Mod29;
    r37   = v37b_q - Fold37W'(q37_q) * Mod37;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[1]) begin
      hx_q <= HashMulX * 32'(pixel_x_i);
      hy_q <= HashMulY * 32'(pixel_y_i);
    end
    if (ctl_i.ld[2]) begin
      mix_q <= h0 ^ (h0 >> 13);
    end
    if (ctl_i.ld[3]) begin
      hash_q <= h1 ^ (h1 >> 16);
    end
    if (ctl_i.ld[4]) begin
      v29_q <= v29_d;
      v37_q <= v37_d;
    end
    if (ctl_i.ld[5]) begin
      q29_q  <= p29[P29W-1:RecipSh];
      q37_q  <= p37[P37W-1:RecipSh];
      v29b_q <= v29_q;
      v37b_q <= v37_q;
    end
    if (ctl_i.ld[6]) begin
      noise_q <= r29[NoiseW-1:0];
      stone_q <= (r37 == '0);
    end
  end

  assign noise_res_o = noise_q;
  assign stone_o     = stone_q;

endmodule

`default_nettype wire

// File: sv/cdts_shade.sv
// ----------------------------------------------------------------------------
// cdts_shade
// Tone pick by depth, darkening of deep tones, noise add (non-solid pixels
// give all-zero outputs) and output register.
`default_nettype none

module cdts_shade import cdts_pkg::*; (
  input  wire logic              clk_i,
  input  wire pipe_ctl_t         ctl_i,
  input  wire logic [RunW-1:0]   depth_i,
  input  wire logic              solid_i,
  input  wire logic [NoiseW-1:0] noise_res_i,
  input  wire logic              stone_i,
  output logic [ChanW-1:0]       red_o,
  output logic [ChanW-1:0]       green_o,
  output logic [ChanW-1:0]       blue_o,
  output logic [ChanW-1:0]       alpha_o
);

  localparam int unsigned ProdW = ChanW + ScaleW;
  localparam int unsigned SumW  = ChanW + 2;

  typedef enum logic [1:0] {
    ToneTop,
    ToneGrass,
    ToneMid,
    ToneDeep
  } tone_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic              solid;
    tone_e             tone;
    logic [ScaleW-1:0] scale;
  } shd_t;

  localparam rgb_t RgbTop   = '{8'd120, 8'd200, 8'd82};
  localparam rgb_t RgbGrass = '{8'd62, 8'd152, 8'd60};
  localparam rgb_t RgbMid   = '{8'd104, 8'd120, 8'd52};
  localparam rgb_t RgbEarth = '{8'd126, 8'd88, 8'd58};
  localparam rgb_t RgbStone = '{8'd110, 8'd108, 8'd112};
  localparam logic signed [SumW-1:0] NoiseBias = 10'sd14;

  function automatic logic [ChanW-1:0] darken(input logic [ChanW-1:0] c,
                                              input logic [ScaleW-1:0] s);
    logic [ProdW-1:0] p;
    p = ProdW'(c) * ProdW'(s);
    return p[ChanW+15:16];
  endfunction

  function automatic logic [ChanW-1:0] add_noise(input logic [ChanW-1:0] c,
                                                 input logic [NoiseW-1:0] n);
    logic signed [SumW-1:0] s;
    s = $signed({2'b00, c}) + $signed(SumW'(n)) - NoiseBias;
    if (s < 0) begin
      return '0;
    end else if (s > $signed(SumW'(255))) begin
      return '1;
    end
    return s[ChanW-1:0];
  endfunction

  shd_t              s3_d, s3_q, s4_q, s5_q, s6_q;
  logic [ScaleW-1:0] dark;
  rgb_t              base, col_d, col_q;
  logic              solid7_q;
  logic [NoiseW-1:0] noise7_q;
  logic [ChanW-1:0]  red_q, green_q, blue_q, alpha_q;

  always_comb begin
    s3_d.solid = solid_i;
    if (depth_i == '0) begin
      s3_d.tone = ToneTop;
    end else if (depth_i <= RunW'(3)) begin
      s3_d.tone = ToneGrass;
    end else if (depth_i <= RunW'(6)) begin
      s3_d.tone = ToneMid;
    end else begin
      s3_d.tone = ToneDeep;
    end
    dark = ScaleW'(depth_i) * DarkStep;
    if (dark > DarkLimit) begin
      dark = DarkLimit;
    end
    s3_d.scale = ScaleOne - dark;
  end

  always_comb begin
    base = stone_i ? RgbStone : RgbEarth;
    unique case (s6_q.tone)
      ToneTop:   col_d = RgbTop;
      ToneGrass: col_d = RgbGrass;
      ToneMid:   col_d = RgbMid;
      ToneDeep: begin
        col_d.red   = darken(base.red, s6_q.scale);
        col_d.green = darken(base.green, s6_q.scale);
        col_d.blue  = darken(base.blue, s6_q.scale);
      end
      default:   col_d = RgbTop;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld[3]) s3_q <= s3_d;
    if (ctl_i.ld[4]) s4_q <= s3_q;
    if (ctl_i.ld[5]) s5_q <= s4_q;
    if (ctl_i.ld[6]) s6_q <= s5_q;
    if (ctl_i.ld[7]) begin
      col_q    <= col_d;
      solid7_q <= s6_q.solid;
      noise7_q <= noise_res_i;
    end
    if (ctl_i.ld[StgN]) begin
      if (solid7_q) begin
        red_q   <= add_noise(col_q.red, noise7_q);
        green_q <= add_noise(col_q.green, noise7_q);
        blue_q  <= add_noise(col_q.blue, noise7_q);
        alpha_q <= '1;
      end else begin
        red_q   <= '0;
        green_q <= '0;
        blue_q  <= '0;
        alpha_q <= '0;
      end
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;
  assign alpha_o = alpha_q;

endmodule

`default_nettype wire
